// ===== rtl/core/unique_key_table_insert_remove_core_macros.svh =====
// assertion macros shared by the table core
`ifndef UNIQUE_KEY_TABLE_INSERT_REMOVE_CORE_MACROS_SVH
`define UNIQUE_KEY_TABLE_INSERT_REMOVE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define UKTIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define UKTIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/uktir_pkg.sv =====
// types and constants of the unique key table
`timescale 1ns / 1ps
package uktir_pkg;

  localparam int ENTRIES = 128;
  localparam int KEY_W   = 48;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 8;
  localparam int OCC_W   = 8;
  localparam int STAT_W  = 3;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CAP_W-1:0] cap_t;
  typedef logic [OCC_W-1:0] occ_t;
  typedef logic [KEY_W-1:0] key_t;

  localparam cap_t CAP_RESET = cap_t'(128);

  typedef enum logic [0:0] {
    K_INSERT = 1'b0,
    K_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_SHIFT
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
    key_t key;
  } cell_bus_t;

  // per-cell position flags
  typedef struct packed {
    logic occupied;
    logic append;
    logic last;
  } cell_sel_t;

endpackage

// ===== rtl/core/uktir_in_if.sv =====
// request channel: operation kind and key
`timescale 1ns / 1ps
interface uktir_in_if;
  logic                      valid;
  logic                      ready;
  logic [0:0]                kind;
  logic [uktir_pkg::KEY_W-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

// ===== rtl/core/uktir_out_if.sv =====
// response channel: status and occupancy
`timescale 1ns / 1ps
interface uktir_out_if;
  logic                         valid;
  logic                         ready;
  logic [uktir_pkg::STAT_W-1:0] status;
  logic [uktir_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output occupancy, input ready);
  modport sink   (input valid, input status, input occupancy, output ready);
endinterface

// ===== rtl/core/uktir_cell.sv =====
// one table cell: key storage, compare and shift token
`timescale 1ns / 1ps
module uktir_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  uktir_pkg::cell_bus_t  bus_i,
  input  uktir_pkg::cell_sel_t  sel_i,
  input  uktir_pkg::key_t       nbr_key_i,
  input  logic                  tok_i,
  output uktir_pkg::key_t       key_o,
  output logic                  tok_o,
  output logic                  done_o
);

  uktir_pkg::key_t key_q, key_d;
  logic            tok_q, tok_d;

  always_comb begin
    tok_d = tok_q;
    if (bus_i.cmp_en) begin
      tok_d = sel_i.occupied && (bus_i.key == key_q);
    end else if (bus_i.shift_en) begin
      tok_d = tok_i;
    end
  end

  always_comb begin
    key_d = key_q;
    if (sel_i.append) begin
      key_d = bus_i.key;
    end else if (bus_i.shift_en && tok_q && !sel_i.last) begin
      // close the hole by pulling the right-hand neighbor in
      key_d = nbr_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o  = key_q;
  assign tok_o  = tok_q;
  assign done_o = tok_q && sel_i.last;

endmodule

// ===== rtl/core/unique_key_table_insert_remove_core.sv =====
// top level of the unique key table: control, capacity register and cell row
// a taken request beat moves the state to decide, which registers its result beat
// insert, full, duplicate and not found pass through idle and decide only, and a new
// request is taken only in idle; a remove with a hit adds the shift state, in which the
//   token walks one cell per cycle from the hit position to the last entry
// reset: count 0, capacity 128, no clearing pass, cell keys undefined until written
`timescale 1ns / 1ps
`include "unique_key_table_insert_remove_core_macros.svh"
module unique_key_table_insert_remove_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  uktir_in_if.sink                in_ch,
  uktir_out_if.source             out_ch,
  input  logic                    cfg_we_i,
  input  logic [uktir_pkg::CAP_W-1:0] cfg_wdata_i
);

  // control state
  uktir_pkg::state_e state_q, state_d;
  uktir_pkg::cnt_t   count_q, count_d;
  uktir_pkg::cap_t   cap_q;

  // latched request
  logic            op_kind_q;
  uktir_pkg::key_t op_key_q;

  // output register
  logic                  out_valid_q, out_valid_d;
  uktir_pkg::status_e    out_status_q, res_status;
  uktir_pkg::occ_t       out_occ_q;
  logic                  res_valid;

  // cell row
  uktir_pkg::cell_bus_t               bus;
  logic [uktir_pkg::ENTRIES-1:0]      tok_vec;
  logic [uktir_pkg::ENTRIES-1:0]      done_vec;
  uktir_pkg::key_t                    key_vec [uktir_pkg::ENTRIES];

  logic            in_beat;
  logic            any_hit;
  logic            done_any;
  logic            full;
  logic            append_en;
  uktir_pkg::cnt_t eff_cap;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign any_hit  = |tok_vec;
  assign done_any = |done_vec;

  // capacity above the table depth saturates at the depth
  assign eff_cap = (int'(cap_q) >= uktir_pkg::ENTRIES) ?
                   uktir_pkg::cnt_t'(uktir_pkg::ENTRIES) : uktir_pkg::cnt_t'(cap_q);
  // capacity test comes before the duplicate test
  assign full    = count_q >= eff_cap;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      uktir_pkg::S_IDLE: begin
        if (in_beat) state_d = uktir_pkg::S_DEC;
      end
      uktir_pkg::S_DEC: begin
        if (op_kind_q == uktir_pkg::K_REMOVE && any_hit) begin
          state_d = uktir_pkg::S_SHIFT;
        end else begin
          state_d = uktir_pkg::S_IDLE;
        end
      end
      uktir_pkg::S_SHIFT: begin
        // token reached the last entry, row is compact again
        if (done_any) state_d = uktir_pkg::S_IDLE;
      end
      default: state_d = uktir_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready  = 1'b0;
    bus.shift_en = 1'b0;
    // compare happens in the request cycle, append in the decide cycle
    bus.cmp_en   = in_beat;
    bus.key      = in_beat ? in_ch.key : op_key_q;
    res_valid    = 1'b0;
    res_status   = uktir_pkg::ST_NOT_FOUND;
    append_en    = 1'b0;
    count_d      = count_q;
    case (state_q)
      uktir_pkg::S_IDLE: begin
        in_ch.ready = !out_valid_q || out_ch.ready;
      end
      uktir_pkg::S_DEC: begin
        res_valid = 1'b1;
        if (op_kind_q == uktir_pkg::K_INSERT) begin
          if (full) begin
            res_status = uktir_pkg::ST_FULL;
          end else if (any_hit) begin
            res_status = uktir_pkg::ST_DUPLICATE;
          end else begin
            res_status = uktir_pkg::ST_INSERTED;
            append_en  = 1'b1;
            count_d    = count_q + uktir_pkg::cnt_t'(1);
          end
        end else begin
          if (any_hit) begin
            // result goes out now, the shift finishes behind it
            res_status = uktir_pkg::ST_REMOVED;
            count_d    = count_q - uktir_pkg::cnt_t'(1);
          end else begin
            res_status = uktir_pkg::ST_NOT_FOUND;
          end
        end
      end
      uktir_pkg::S_SHIFT: begin
        bus.shift_en = !done_any;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // output slot is always free when a result lands: one request in flight
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ch.ready) out_valid_d = 1'b0;
    if (res_valid)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uktir_pkg::S_IDLE;
      count_q     <= '0;
      cap_q       <= uktir_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_kind_q <= in_ch.kind;
      op_key_q  <= in_ch.key;
    end
    if (res_valid) begin
      out_status_q <= res_status;
      out_occ_q    <= uktir_pkg::occ_t'(count_d);
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.status    = out_status_q;
  assign out_ch.occupancy = out_occ_q;

  // row of cells; token moves right, keys move left
  for (genvar i = 0; i < uktir_pkg::ENTRIES; i++) begin : g_cell
    localparam uktir_pkg::cnt_t Idx = uktir_pkg::cnt_t'(i);
    uktir_pkg::cell_sel_t sel;
    uktir_pkg::key_t      nbr_key;
    logic                 tok_in;

    assign sel.occupied = Idx < count_q;
    assign sel.last     = count_q == Idx;
    assign sel.append   = append_en && (count_q == Idx);

    if (i == uktir_pkg::ENTRIES - 1) begin : g_end
      assign nbr_key = '0;
    end else begin : g_mid
      assign nbr_key = key_vec[i+1];
    end

    if (i == 0) begin : g_first
      assign tok_in = 1'b0;
    end else begin : g_rest
      assign tok_in = tok_vec[i-1];
    end

    uktir_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .bus_i     (bus),
      .sel_i     (sel),
      .nbr_key_i (nbr_key),
      .tok_i     (tok_in),
      .key_o     (key_vec[i]),
      .tok_o     (tok_vec[i]),
      .done_o    (done_vec[i])
    );
  end

  // requests are taken only between operations
  `UKTIR_ASSERT_IMP(a_ready_idle, in_ch.ready, state_q == uktir_pkg::S_IDLE, "ready outside idle")
  // keys are unique, so at most one cell holds the token
  `UKTIR_ASSERT_IMP(a_tok_onehot, 1'b1, $onehot0(tok_vec), "more than one token")
  // count never passes the table depth
  `UKTIR_ASSERT_IMP(a_count_max, 1'b1, int'(count_q) <= uktir_pkg::ENTRIES, "count overflow")
  // every taken request is decided in the next cycle
  `UKTIR_ASSERT_NXT(a_beat_dec, in_beat, state_q == uktir_pkg::S_DEC && out_valid_d, "no result")

endmodule
